FILE: rtl/dac_pkg.sv
// Package for the Doppler angle correction block: fixed widths, register
// indexes and the shared control struct. Depends on nothing.
package dac_pkg;
    localparam int CRD_W   = 13;
    localparam int FLOOR_W = 16;
    localparam int COS_W   = 16;
    localparam int OUT_W   = 40;
    localparam int IDX_W   = 3;
    localparam int SAMP_W  = 8;
    localparam logic [IDX_W-1:0] REG_CENTER_X     = 3'd0;
    localparam logic [IDX_W-1:0] REG_CENTER_Y     = 3'd1;
    localparam logic [IDX_W-1:0] REG_CENTER_Z     = 3'd2;
    localparam logic [IDX_W-1:0] REG_TRANSDUCER_X = 3'd3;
    localparam logic [IDX_W-1:0] REG_TRANSDUCER_Y = 3'd4;
    localparam logic [IDX_W-1:0] REG_TRANSDUCER_Z = 3'd5;
    localparam logic [IDX_W-1:0] REG_COS_FLOOR    = 3'd6;

    typedef struct packed {
        logic advance;
        logic flush;
    } pipe_ctrl_t;
endpackage

FILE: rtl/dac_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on dac_pkg for the pipeline control struct.
module dac_sqrt #(
    parameter int IN_W = 54,
    parameter int TAG_W = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dac_pkg::pipe_ctrl_t   ctrl,
    input  logic                  in_valid,
    input  logic [IN_W-1:0]       in_val,
    input  logic [TAG_W-1:0]      in_tag,
    output logic                  out_valid,
    output logic [(IN_W+1)/2-1:0] out_root,
    output logic [TAG_W-1:0]      out_tag
);
    import dac_pkg::*;
    localparam int RW = (IN_W + 1) / 2;
    localparam int NW = 2 * RW;

    logic [NW-1:0]    rem_reg  [RW+1];
    logic [NW-1:0]    n_reg    [RW+1];
    logic [RW-1:0]    root_reg [RW+1];
    logic [TAG_W-1:0] tag_reg  [RW+1];
    logic [RW:0]      v_reg;

    always_comb begin
        rem_reg[0]  = '0;
        n_reg[0]    = NW'(in_val);
        root_reg[0] = '0;
        tag_reg[0]  = in_tag;
        v_reg[0]    = in_valid;
    end

    // Restoring digit recurrence: two bits of the radicand per stage.
    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [NW-1:0] rem_next;
        logic [NW-1:0] trial;
        logic [NW-1:0] rem_sh;
        logic [NW-1:0] n_next;
        logic [RW-1:0] root_next;
        always_comb begin
            rem_sh = {rem_reg[k][NW-3:0], n_reg[k][NW-1:NW-2]};
            n_next = {n_reg[k][NW-3:0], 2'b00};
            trial  = NW'({root_reg[k][RW-1:0], 2'b01});
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[k][RW-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[k][RW-2:0], 1'b0};
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (ctrl.advance) begin
                v_reg[k+1] <= v_reg[k];
            end
            if (ctrl.advance) begin
                rem_reg[k+1]  <= rem_next;
                n_reg[k+1]    <= n_next;
                root_reg[k+1] <= root_next;
                tag_reg[k+1]  <= tag_reg[k];
            end
        end
    end

    assign out_valid = v_reg[RW] & ~ctrl.flush;
    assign out_root  = root_reg[RW];
    assign out_tag   = tag_reg[RW];
endmodule

FILE: rtl/dac_div.sv
// Pipelined restoring unsigned divider, one quotient bit per stage.
// Depends on dac_pkg for the pipeline control struct.
module dac_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 40,
    parameter int TAG_W = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dac_pkg::pipe_ctrl_t ctrl,
    input  logic                in_valid,
    input  logic [NUM_W-1:0]    in_num,
    input  logic [DEN_W-1:0]    in_den,
    input  logic [TAG_W-1:0]    in_tag,
    output logic                out_valid,
    output logic [NUM_W-1:0]    out_quo,
    output logic [TAG_W-1:0]    out_tag
);
    import dac_pkg::*;
    localparam int RW = DEN_W + 1;

    logic [RW-1:0]    rem_reg [NUM_W+1];
    logic [NUM_W-1:0] q_reg   [NUM_W+1];
    logic [DEN_W-1:0] d_reg   [NUM_W+1];
    logic [TAG_W-1:0] tag_reg [NUM_W+1];
    logic [NUM_W:0]   v_reg;

    always_comb begin
        rem_reg[0] = '0;
        q_reg[0]   = in_num;
        d_reg[0]   = in_den;
        tag_reg[0] = in_tag;
        v_reg[0]   = in_valid;
    end

    // Shift the numerator through q_reg; quotient bits fill from the bottom.
    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [RW-1:0]    rem_sh;
        logic [RW-1:0]    rem_next;
        logic             qbit;
        always_comb begin
            rem_sh = {rem_reg[k][RW-2:0], q_reg[k][NUM_W-1]};
            qbit   = rem_sh >= RW'(d_reg[k]);
            rem_next = qbit ? rem_sh - RW'(d_reg[k]) : rem_sh;
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (ctrl.advance) begin
                v_reg[k+1] <= v_reg[k];
            end
            if (ctrl.advance) begin
                rem_reg[k+1] <= rem_next;
                q_reg[k+1]   <= {q_reg[k][NUM_W-2:0], qbit};
                d_reg[k+1]   <= d_reg[k];
                tag_reg[k+1] <= tag_reg[k];
            end
        end
    end

    assign out_valid = v_reg[NUM_W] & ~ctrl.flush;
    assign out_quo   = q_reg[NUM_W];
    assign out_tag   = tag_reg[NUM_W];
endmodule

FILE: rtl/doppler_angle_correct_voxel_top.sv
// Doppler angle correction: top level with register file, vector front end,
// cosine and quotient pipelines. Depends on dac_pkg, dac_sqrt and dac_div.
//
// Usage: s_ channel takes one voxel word per cycle while s_tready is high
// (position and sample); m_ channel returns one word per voxel in the same
// order: the corrected velocity in signed Q23.16 (saturated) and the
// below-floor flag. cfg_ channel writes the center, transducer and cos_floor
// registers; write only while no voxel is in flight.
// Throughput: one voxel per cycle while the receiver does not stall, set by
// the fully pipelined square root, cosine divider and quotient divider.
// Stages: 4 front-end + 32 sqrt + 48 cosine divide + 1 divisor select
// + 40 quotient divide (24 + FRAC_BITS) + 1 output at the default FRAC_BITS.
// The whole pipeline advances as one when the output register is free or is
// being taken; when the receiver stalls, every stage holds and s_tready drops,
// so nothing is lost or repeated.
// Reset: synchronous active-low aresetn clears all valid bits and restores
// register defaults (zero coordinates, cos_floor of one).
module doppler_angle_correct_voxel_top #(
    parameter int MAX_DIM   = 1024,
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // voxel_x[9:0], voxel_y[19:10], voxel_z[29:20], sample[37:30], zero pad
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // corrected[39:0]
    output logic [39:0] m_tdata,
    // below_floor[0]
    output logic        m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import dac_pkg::*;

    localparam int PW   = 10;
    localparam int DW   = CRD_W + 2;
    localparam int SQW  = 2 * DW + 2;
    localparam int LW   = 2 * SQW;
    localparam int RTW  = (LW + 1) / 2;
    localparam int DIVN = COS_W + FRAC_BITS + 8;
    // Clamp only matters when MAX_DIM is below the coordinate field's range.
    localparam int MAXC_I = (MAX_DIM < (1 << PW)) ? MAX_DIM - 1 : (1 << PW) - 1;
    localparam logic [PW-1:0] MAXC = PW'(MAXC_I);
    localparam logic [63:0] MAXV = (64'd1 << (OUT_W-1)) - 64'd1;

    pipe_ctrl_t ctrl;
    logic out_full_reg;

    assign ctrl.advance = ~out_full_reg | m_tready;
    assign ctrl.flush   = 1'b0;
    assign s_tready     = ctrl.advance;
    assign cfg_ready    = 1'b1;

    // Register file.
    logic signed [CRD_W-1:0] cen_reg [3];
    logic signed [CRD_W-1:0] trn_reg [3];
    logic [FLOOR_W-1:0]      floor_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                cen_reg[i] <= '0;
                trn_reg[i] <= '0;
            end
            floor_reg <= FLOOR_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CENTER_X:     cen_reg[0] <= cfg_data[CRD_W-1:0];
                REG_CENTER_Y:     cen_reg[1] <= cfg_data[CRD_W-1:0];
                REG_CENTER_Z:     cen_reg[2] <= cfg_data[CRD_W-1:0];
                REG_TRANSDUCER_X: trn_reg[0] <= cfg_data[CRD_W-1:0];
                REG_TRANSDUCER_Y: trn_reg[1] <= cfg_data[CRD_W-1:0];
                REG_TRANSDUCER_Z: trn_reg[2] <= cfg_data[CRD_W-1:0];
                REG_COS_FLOOR:    floor_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [FLOOR_W-1:0] floor_eff;
    assign floor_eff = (floor_reg == '0) ? FLOOR_W'(1) : floor_reg;

    // Stage 1: clamp coordinates, form difference vectors.
    logic [PW-1:0] pos [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pos[i] = s_tdata[i*PW +: PW];
            if (pos[i] > MAXC) pos[i] = MAXC;
        end
    end

    logic                 v1_reg;
    logic signed [DW-1:0] t1_reg [3];
    logic signed [DW-1:0] c1_reg [3];
    logic [SAMP_W-1:0]    smp1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (ctrl.advance) begin
            v1_reg <= s_tvalid;
        end
        if (ctrl.advance) begin
            for (int i = 0; i < 3; i++) begin
                t1_reg[i] <= DW'(trn_reg[i]) - DW'({1'b0, pos[i]});
                c1_reg[i] <= DW'(cen_reg[i]) - DW'({1'b0, pos[i]});
            end
            smp1_reg <= s_tdata[3*PW +: SAMP_W];
        end
    end

    // Stage 2: products per axis.
    logic                          v2_reg;
    logic signed [2*DW-1:0]        dp2_reg [3];
    logic [2*DW-1:0]               tt2_reg [3];
    logic [2*DW-1:0]               cc2_reg [3];
    logic [SAMP_W-1:0]             smp2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (ctrl.advance) begin
            v2_reg <= v1_reg;
        end
        if (ctrl.advance) begin
            for (int i = 0; i < 3; i++) begin
                dp2_reg[i] <= t1_reg[i] * c1_reg[i];
                tt2_reg[i] <= (2*DW)'(t1_reg[i] * t1_reg[i]);
                cc2_reg[i] <= (2*DW)'(c1_reg[i] * c1_reg[i]);
            end
            smp2_reg <= smp1_reg;
        end
    end

    // Stage 3: sums.
    logic                   v3_reg;
    logic signed [SQW-1:0]  dot3_reg;
    logic [SQW-1:0]         lt3_reg;
    logic [SQW-1:0]         lc3_reg;
    logic [SAMP_W-1:0]      smp3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (ctrl.advance) begin
            v3_reg <= v2_reg;
        end
        if (ctrl.advance) begin
            dot3_reg <= SQW'(dp2_reg[0]) + SQW'(dp2_reg[1]) + SQW'(dp2_reg[2]);
            lt3_reg  <= SQW'(tt2_reg[0]) + SQW'(tt2_reg[1]) + SQW'(tt2_reg[2]);
            lc3_reg  <= SQW'(cc2_reg[0]) + SQW'(cc2_reg[1]) + SQW'(cc2_reg[2]);
            smp3_reg <= smp2_reg;
        end
    end

    // Stage 4: length product and |dot|.
    logic              v4_reg;
    logic [LW-1:0]     l4_reg;
    logic [SQW-1:0]    ad4_reg;
    logic              dneg4_reg;
    logic [SAMP_W-1:0] smp4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (ctrl.advance) begin
            v4_reg <= v3_reg;
        end
        if (ctrl.advance) begin
            l4_reg    <= lt3_reg * lc3_reg;
            ad4_reg   <= dot3_reg[SQW-1] ? SQW'(-dot3_reg) : SQW'(dot3_reg);
            dneg4_reg <= dot3_reg[SQW-1];
            smp4_reg  <= smp3_reg;
        end
    end

    // Square root of the length product.
    localparam int T1W = SQW + 1 + SAMP_W;
    logic             sq_v;
    logic [RTW-1:0]   sq_root;
    logic [T1W-1:0]   sq_tag;

    dac_sqrt #(.IN_W(LW), .TAG_W(T1W)) u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl),
        .in_valid(v4_reg), .in_val(l4_reg),
        .in_tag({smp4_reg, dneg4_reg, ad4_reg}),
        .out_valid(sq_v), .out_root(sq_root), .out_tag(sq_tag)
    );

    // Cosine magnitude: (|dot| << 16) / root. A zero root gives all ones,
    // which is masked to zero instead of being clamped.
    localparam int CNW = SQW + COS_W;
    localparam int T2W = T1W + 1;
    logic           cd_v;
    logic [CNW-1:0] cd_q;
    logic [T2W-1:0] cd_tag;

    dac_div #(.NUM_W(CNW), .DEN_W(RTW), .TAG_W(T2W)) u_cosdiv (
        .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl),
        .in_valid(sq_v), .in_num({sq_tag[SQW-1:0], COS_W'(0)}), .in_den(sq_root),
        .in_tag({sq_root == '0, sq_tag}),
        .out_valid(cd_v), .out_quo(cd_q), .out_tag(cd_tag)
    );

    // Stage: clamp cosine, pick divisor, form numerator.
    logic [COS_W:0] cmag;
    logic           below;
    logic [SAMP_W-1:0] smp_c;
    logic signed [SAMP_W:0] dsig;
    assign smp_c = cd_tag[SQW+1 +: SAMP_W];
    assign dsig  = $signed({1'b0, smp_c}) - (SAMP_W+1)'(128);
    always_comb begin
        if (cd_tag[T2W-1]) cmag = '0;
        else if (cd_q > CNW'(1 << COS_W)) cmag = (COS_W+1)'(1 << COS_W);
        else cmag = cd_q[COS_W:0];
        below = cmag <= (COS_W+1)'(floor_eff);
    end

    localparam int T3W = 2;
    logic              v5_reg;
    logic [DIVN-1:0]   num5_reg;
    logic [COS_W:0]    den5_reg;
    logic [T3W-1:0]    tag5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (ctrl.advance) begin
            v5_reg <= cd_v;
        end
        if (ctrl.advance) begin
            num5_reg <= DIVN'(dsig[SAMP_W] ? -dsig : dsig) << (COS_W + FRAC_BITS);
            den5_reg <= below ? (COS_W+1)'(floor_eff) : cmag;
            // Negate when sample sign differs from the divisor sign.
            tag5_reg <= {below, dsig[SAMP_W] ^ (~below & cd_tag[SQW])};
        end
    end

    logic            qd_v;
    logic [DIVN-1:0] qd_q;
    logic [T3W-1:0]  qd_tag;

    dac_div #(.NUM_W(DIVN), .DEN_W(COS_W+1), .TAG_W(T3W)) u_qdiv (
        .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl),
        .in_valid(v5_reg), .in_num(num5_reg), .in_den(den5_reg), .in_tag(tag5_reg),
        .out_valid(qd_v), .out_quo(qd_q), .out_tag(qd_tag)
    );

    // Output register: sign and saturate. Compare in 64 bits so any
    // quotient width up to 64 bits works.
    logic [63:0] q64;
    assign q64 = 64'(qd_q);

    logic signed [OUT_W-1:0] res;
    always_comb begin
        if (qd_tag[0]) begin
            if (q64 > MAXV + 64'd1) res = {1'b1, {(OUT_W-1){1'b0}}};
            else res = OUT_W'(-$signed({1'b0, qd_q}));
        end else begin
            if (q64 > MAXV) res = {1'b0, {(OUT_W-1){1'b1}}};
            else res = OUT_W'(qd_q);
        end
    end

    logic [OUT_W-1:0] out_data_reg;
    logic             out_flag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_full_reg <= 1'b0;
        end else if (ctrl.advance) begin
            out_full_reg <= qd_v;
        end
        if (ctrl.advance) begin
            out_data_reg <= res;
            out_flag_reg <= qd_tag[1];
        end
    end

    assign m_tvalid = out_full_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_flag_reg;
endmodule

FILE: rtl/dac_checker.sv
// Port-level checker for the Doppler angle correction top level, with bind.
// Depends only on the top level's ports.
module dac_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser
);
    // Hold the word while the receiver stalls.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed under stall");
    // Input side opens whenever the output is free.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with empty output");
    // Stall stops intake.
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken during output stall");
    // Nothing appears right after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");
endmodule

bind doppler_angle_correct_voxel_top dac_checker u_dac_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

FILE: dv/tb.sv
// Testbench for doppler_angle_correct_voxel_top: drives voxel words and register
// writes, predicts each corrected word in 64-bit arithmetic and checks it.
// Depends on dac_pkg and the RTL of the block.
module tb;
    import dac_pkg::*;

    localparam int MAX_DIM   = 1024;
    localparam int FRAC_BITS = 16;
    localparam int LATENCY   = 100;
    localparam int WDOG_MAX  = 20000;

    typedef struct packed {
        logic [7:0] sample;
        logic [9:0] vz;
        logic [9:0] vy;
        logic [9:0] vx;
    } voxel_t;

    typedef struct {
        logic [39:0] corrected;
        logic        below_floor;
    } velocity_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    doppler_angle_correct_voxel_top #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) dut (.*);

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Predictor copy of the register file.
    logic signed [12:0] ctr [3];
    logic signed [12:0] xdr [3];
    logic [15:0]        cos_floor;

    voxel_t    voxel_q [$];   // words waiting for the driver
    velocity_t velocity_q [$]; // expected results in order
    int        mismatches = 0;
    int        sent = 0, got = 0, below_seen = 0;
    bit        hold_sender = 0;
    int        stall_cycles = 0;

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic velocity_t correct_velocity(voxel_t v);
        longint p [3];
        longint dot, lt, lc, t, c, d, cosq, divisor, res, fl;
        longint unsigned s, ad, cmag, num, q;
        velocity_t r;
        bit below;
        p[0] = v.vx; p[1] = v.vy; p[2] = v.vz;
        dot = 0; lt = 0; lc = 0;
        for (int i = 0; i < 3; i++) begin
            if (p[i] >= MAX_DIM) p[i] = MAX_DIM - 1;
            t = longint'(xdr[i]) - p[i];
            c = longint'(ctr[i]) - p[i];
            dot += t * c;
            lt += t * t;
            lc += c * c;
        end
        d = longint'(v.sample) - 128;
        s = int_sqrt(longint'(lt) * longint'(lc));
        if (s == 0) begin
            cosq = 0;
        end else begin
            ad = dot < 0 ? -dot : dot;
            cmag = (ad << COS_W) / s;
            if (cmag > (64'd1 << COS_W)) cmag = 64'd1 << COS_W;
            cosq = dot < 0 ? -longint'(cmag) : longint'(cmag);
        end
        fl = cos_floor == 0 ? 1 : cos_floor;
        cmag = cosq < 0 ? -cosq : cosq;
        below = cmag <= fl;
        divisor = below ? fl : cosq;
        num = longint'(d < 0 ? -d : d) << (COS_W + FRAC_BITS);
        q = num / longint'(divisor < 0 ? -divisor : divisor);
        if ((d < 0) != (divisor < 0))
            res = q > (64'd1 << 39) ? -(64'sd1 <<< 39) : -longint'(q);
        else
            res = q > ((64'd1 << 39) - 1) ? (64'sd1 <<< 39) - 1 : longint'(q);
        r.corrected = res[39:0];
        r.below_floor = below;
        return r;
    endfunction

    // Write one register while the pipeline is empty and track it.
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        case (idx)
            REG_CENTER_X, REG_CENTER_Y, REG_CENTER_Z: ctr[idx] = val[12:0];
            REG_TRANSDUCER_X, REG_TRANSDUCER_Y, REG_TRANSDUCER_Z:
                xdr[idx - REG_TRANSDUCER_X] = val[12:0];
            REG_COS_FLOOR: cos_floor = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (voxel_q.size() != 0 || velocity_q.size() != 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'h0FFF;               // most positive
            1: return 16'h1000;               // most negative
            2: return 16'($urandom_range(0, 1023));
            3: return 16'($urandom_range(0, 8191));
            default: return 16'($urandom_range(0, 1200));
        endcase
    endfunction

    function automatic voxel_t rand_voxel();
        voxel_t v;
        v = 38'({$urandom, $urandom});
        if ($urandom_range(0, 3) == 0) begin
            // sit on the transducer position so a vector can collapse to zero length
            v.vx = xdr[0][9:0];
            v.vy = xdr[1][9:0];
            v.vz = xdr[2][9:0];
        end
        return v;
    endfunction

    // Queue one voxel and record what it should produce.
    task automatic push_voxel(voxel_t v);
        voxel_q.push_back(v);
        velocity_q.push_back(correct_velocity(v));
    endtask

    initial begin
        voxel_t v;
        logic [15:0] floors [4] = '{16'd0, 16'd1, 16'hFFFF, 16'd300};
        for (int i = 0; i < 3; i++) begin
            ctr[i] = 0;
            xdr[i] = 0;
        end
        cos_floor = 1;
        repeat (5) @(posedge aclk);
        aresetn <= 1;

        // Directed: reset registers give zero-length vectors at the origin.
        v = '0; push_voxel(v);
        v.sample = 8'hFF; push_voxel(v);
        v.sample = 8'h80; push_voxel(v);
        drain();
        write_reg(REG_CENTER_X, 16'h0FFF);
        write_reg(REG_CENTER_Y, 16'h1000);
        write_reg(REG_CENTER_Z, 16'd500);
        write_reg(REG_TRANSDUCER_X, 16'h1000);
        write_reg(REG_TRANSDUCER_Y, 16'h0FFF);
        write_reg(REG_TRANSDUCER_Z, 16'd0);
        write_reg(REG_COS_FLOOR, 16'd0);
        foreach (floors[k]) begin
            for (int s = 0; s < 4; s++) begin
                v.vx = s[0] ? 10'h3FF : 10'h000;
                v.vy = s[1] ? 10'h3FF : 10'h000;
                v.vz = 10'($urandom_range(0, 1023));
                v.sample = s == 0 ? 8'h00 : s == 1 ? 8'hFF : 8'($urandom);
                push_voxel(v);
            end
            drain();
            write_reg(REG_COS_FLOOR, floors[(k + 1) % 4]);
        end
        // Collinear, tiny floor: |cos| = 1 gives the largest divisor and the smallest quotient.
        write_reg(REG_CENTER_X, 16'd900);
        write_reg(REG_CENTER_Y, 16'd0);
        write_reg(REG_CENTER_Z, 16'd0);
        write_reg(REG_TRANSDUCER_X, 16'd1000);
        write_reg(REG_TRANSDUCER_Y, 16'd0);
        write_reg(REG_TRANSDUCER_Z, 16'd0);
        write_reg(REG_COS_FLOOR, 16'd1);
        v = '0; push_voxel(v);
        v.sample = 8'hFF; push_voxel(v);
        drain();

        // Random phases with fresh register settings in between.
        for (int ph = 0; ph < 14; ph++) begin
            for (int r = REG_CENTER_X; r <= REG_TRANSDUCER_Z; r++)
                write_reg(r[2:0], rand_coord());
            case (ph % 4)
                0: write_reg(REG_COS_FLOOR, 16'hFFFF);
                1: write_reg(REG_COS_FLOOR, 16'd0);
                default: write_reg(REG_COS_FLOOR, 16'($urandom_range(0, 4000)));
            endcase
            for (int n = 0; n < 100; n++) push_voxel(rand_voxel());
            if (ph == 5) begin
                // let part of the phase go out, then pause until every result has come
                while (voxel_q.size() > 50) @(posedge aclk);
                hold_sender = 1;
                while (velocity_q.size() != voxel_q.size()) @(posedge aclk);
                hold_sender = 0;
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("Sent %0d voxels and checked %0d results over directed corners and",
                     sent, got);
            $display("random register settings; %0d fell below the floor.", below_seen);
            $display("PASS");
        end else begin
            $display("Covered %0d voxels, %0d mismatches.", got, mismatches);
            $display("FAIL");
        end
        $finish;
    end

    // Driver: bursts and gaps; hold an offered word until it is taken.
    int burst = 0, gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                void'(voxel_q.pop_front());
                sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap > 0) begin
                    gap--;
                    s_tvalid <= 0;
                end else if (!hold_sender && voxel_q.size() != 0) begin
                    s_tvalid <= 1;
                    s_tdata <= {2'b00, voxel_q[0]};
                    if (burst == 0) begin
                        burst = $urandom_range(1, 40);
                        gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : 0;
                    end else begin
                        burst--;
                    end
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // Receiver: random stalls, one long hold-off while the sender has plenty queued.
    always @(posedge aclk) begin
        if (got >= 300 && voxel_q.size() >= 50 && stall_cycles == 0) stall_cycles = 400;
        if (stall_cycles > 0) begin
            stall_cycles--;
            m_tready <= stall_cycles == 0;
            if (stall_cycles == 0) stall_cycles = -1;
        end else begin
            m_tready <= ($urandom_range(0, 15) < 2) ? 0 : 1;
        end
    end

    // Monitor: compare each accepted word with the oldest expectation.
    velocity_t want;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got++;
            if (velocity_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", m_tdata);
            end else begin
                want = velocity_q.pop_front();
                if (want.below_floor) below_seen++;
                if (m_tdata !== want.corrected || m_tuser !== want.below_floor) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word %0d: corrected exp %h got %h, below exp %b got %b",
                                 got, want.corrected, m_tdata, want.below_floor, m_tuser);
                end
            end
        end
    end

    // Watchdog: count cycles in which nothing is accepted while results are expected.
    int idle = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || velocity_q.size() == 0)
            idle <= 0;
        else
            idle <= idle + 1;
        if (idle >= WDOG_MAX) begin
            $display("FAIL");
            $finish;
        end
    end
endmodule

FILE: sim.f
rtl/dac_pkg.sv
rtl/dac_sqrt.sv
rtl/dac_div.sv
rtl/doppler_angle_correct_voxel_top.sv
rtl/dac_checker.sv
dv/tb.sv
